/* hdl/nprf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nprf_pkg: shared types and constants
// Widths, codes and fixed-point constants for the polynomial root finder.
// ----------------------------------------------------------------------------
package nprf_pkg;

    localparam int MAX_COEFS = 16;
    localparam int IDX_W     = $clog2(MAX_COEFS);
    localparam int CNT_W     = $clog2(MAX_COEFS + 1);

    localparam logic [31:0] FAIL_ROOT = 32'h270F_0000;

    localparam logic [1:0] CFG_NUM_COEFS = 2'd0;
    localparam logic [1:0] CFG_TOLERANCE = 2'd1;
    localparam logic [1:0] CFG_ITER_LIM  = 2'd2;
    localparam logic [1:0] CFG_STEP_H    = 2'd3;

    localparam logic [1:0] ST_CONVERGED  = 2'd0;
    localparam logic [1:0] ST_LIMIT      = 2'd1;
    localparam logic [1:0] ST_ZERO_DERIV = 2'd2;

    localparam logic KIND_COEF  = 1'b0;
    localparam logic KIND_SOLVE = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [3:0]        coef_index;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] root;
        logic [1:0]         status;
        logic [9:0]         iterations_used;
    } out_item_t;

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* hdl/nprf_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nprf_in_if / nprf_out_if: valid-ready channels
// Carry input transactions and result transactions.
// ----------------------------------------------------------------------------
interface nprf_in_if;
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [3:0]               coef_index;
    logic signed [31:0]       value;
    modport source (output valid, kind, coef_index, value, input ready);
    modport sink   (input valid, kind, coef_index, value, output ready);
endinterface

interface nprf_out_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       root;
    logic [1:0]               status;
    logic [9:0]               iterations_used;
    modport source (output valid, root, status, iterations_used, input ready);
    modport sink   (input valid, root, status, iterations_used, output ready);
endinterface

/* hdl/newton_polynomial_root_finder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_polynomial_root_finder: Newton-Raphson root search in Q16.16
// A solve runs up to limit-1 iterations of three Horner passes (one shared
// multiplier, a multiply state and an add state per term) and two divisions.
// One transaction at a time; ready is low while a solve runs.
// Reset clears control state and loads the register defaults; the
// coefficient table is undefined until written.
// ----------------------------------------------------------------------------
module newton_polynomial_root_finder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    nprf_in_if.sink     in_ch,
    nprf_out_if.source  out_ch
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_START  = 10'b00_0000_0010,
        S_HMUL   = 10'b00_0000_0100,
        S_HADD   = 10'b00_0000_1000,
        S_PDONE  = 10'b00_0001_0000,
        S_DDIV   = 10'b00_0010_0000,
        S_NDIV   = 10'b00_0100_0000,
        S_STEP   = 10'b00_1000_0000,
        S_OUT    = 10'b01_0000_0000,
        S_WAIT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [4:0]  num_coefs_reg;
    logic [30:0] tol_reg;
    logic [9:0]  lim_reg;
    logic [16:0] h_reg;

    logic signed [31:0] coef_mem [nprf_pkg::MAX_COEFS];

    logic signed [31:0] x0_reg, x0_next;
    logic signed [31:0] xe_reg, xe_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [31:0] phi_reg, phi_next;
    logic signed [31:0] plo_reg, plo_next;
    logic signed [31:0] d_reg, d_next;
    logic signed [31:0] m_reg, m_next;
    logic [1:0]  pass_reg, pass_next;
    logic [nprf_pkg::CNT_W-1:0] term_reg, term_next;
    logic [9:0]  iter_reg, iter_next;
    logic [9:0]  steps_reg, steps_next;
    logic signed [31:0] root_reg, root_next;
    logic [1:0]  status_reg, status_next;

    logic               div_start;
    logic signed [63:0] div_num, div_den;
    logic               div_done;
    logic signed [31:0] div_q;

    logic [nprf_pkg::CNT_W-1:0] n_used;
    logic signed [31:0] h32;
    logic signed [63:0] prod, prod_r;
    logic signed [31:0] x_step;
    logic signed [63:0] diff64;
    logic [63:0] adiff;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_coefs_reg <= 5'd1;
            tol_reg       <= 31'd66;
            lim_reg       <= 10'd100;
            h_reg         <= 17'd328;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nprf_pkg::CFG_NUM_COEFS: num_coefs_reg <= cfg_data[4:0];
                nprf_pkg::CFG_TOLERANCE: tol_reg       <= cfg_data;
                nprf_pkg::CFG_ITER_LIM:  lim_reg       <= cfg_data[9:0];
                nprf_pkg::CFG_STEP_H:    h_reg         <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    assign n_used = (num_coefs_reg == 5'd0) ? nprf_pkg::CNT_W'(1) :
                    (num_coefs_reg > 5'(nprf_pkg::MAX_COEFS)) ?
                        nprf_pkg::CNT_W'(nprf_pkg::MAX_COEFS) :
                        nprf_pkg::CNT_W'(num_coefs_reg);
    assign h32 = (h_reg == 17'd0) ? 32'sd1 : $signed({15'd0, h_reg});

    // Coefficient table writes.
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready && in_ch.kind == nprf_pkg::KIND_COEF)
            coef_mem[in_ch.coef_index] <= in_ch.value;
    end

    // Shared multiplier with rounding, ties toward plus infinity.
    assign prod   = 64'(y_reg) * 64'(xe_reg);
    assign prod_r = (prod + 64'sd32768) >>> 16;

    // New estimate and the size of the step that produced it.
    assign x_step = nprf_pkg::sat32(64'(x0_reg) - 64'(m_reg));
    assign diff64 = 64'(x_step) - 64'(x0_reg);
    assign adiff  = diff64[63] ? 64'(-diff64) : 64'(diff64);

    nprf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        x0_next     = x0_reg;
        xe_next     = xe_reg;
        y_next      = y_reg;
        phi_next    = phi_reg;
        plo_next    = plo_reg;
        d_next      = d_reg;
        m_next      = m_reg;
        pass_next   = pass_reg;
        term_next   = term_reg;
        iter_next   = iter_reg;
        steps_next  = steps_reg;
        root_next   = root_reg;
        status_next = status_reg;
        div_start   = 1'b0;
        div_num     = 64'(phi_reg - plo_reg) <<< 16;
        div_den     = 64'(h32) <<< 1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.kind == nprf_pkg::KIND_SOLVE)
                begin
                    x0_next     = in_ch.value;
                    iter_next   = 10'd1;
                    steps_next  = '0;
                    root_next   = nprf_pkg::FAIL_ROOT;
                    status_next = nprf_pkg::ST_LIMIT;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                // Begin an iteration with the pass at x + h, or finish once the limit is reached.
                if (iter_reg >= lim_reg)
                    state_next = S_OUT;
                else
                begin
                    pass_next  = 2'd0;
                    xe_next    = nprf_pkg::sat32(64'(x0_reg) + 64'(h32));
                    y_next     = coef_mem[0];
                    term_next  = nprf_pkg::CNT_W'(1);
                    state_next = S_HMUL;
                end
            end
            S_HMUL:
            begin
                if (term_reg >= n_used)
                    state_next = S_PDONE;
                else
                begin
                    m_next     = nprf_pkg::sat32(prod_r);
                    state_next = S_HADD;
                end
            end
            S_HADD:
            begin
                y_next = nprf_pkg::sat32(64'(m_reg) +
                         64'(coef_mem[term_reg[nprf_pkg::IDX_W-1:0]]));
                term_next  = term_reg + nprf_pkg::CNT_W'(1);
                state_next = S_HMUL;
            end
            S_PDONE:
            begin
                y_next    = coef_mem[0];
                term_next = nprf_pkg::CNT_W'(1);
                case (pass_reg)
                    2'd0:
                    begin
                        phi_next   = y_reg;
                        xe_next    = nprf_pkg::sat32(64'(x0_reg) - 64'(h32));
                        pass_next  = 2'd1;
                        state_next = S_HMUL;
                    end
                    2'd1:
                    begin
                        plo_next   = y_reg;
                        div_num    = (64'(phi_reg) - 64'(y_reg)) <<< 16;
                        div_start  = 1'b1;
                        state_next = S_DDIV;
                    end
                    default:
                    begin
                        div_num    = 64'(y_reg) <<< 16;
                        div_den    = 64'(d_reg);
                        div_start  = 1'b1;
                        state_next = S_NDIV;
                    end
                endcase
            end
            S_DDIV:
            begin
                if (div_done)
                begin
                    d_next = div_q;
                    if (div_q == 32'sd0)
                    begin
                        status_next = nprf_pkg::ST_ZERO_DERIV;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        xe_next    = x0_reg;
                        y_next     = coef_mem[0];
                        term_next  = nprf_pkg::CNT_W'(1);
                        pass_next  = 2'd2;
                        state_next = S_HMUL;
                    end
                end
            end
            S_NDIV:
            begin
                if (div_done)
                begin
                    m_next     = div_q;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                steps_next = steps_reg + 10'd1;
                if (adiff <= 64'(tol_reg))
                begin
                    root_next   = x_step;
                    status_next = nprf_pkg::ST_CONVERGED;
                    state_next  = S_OUT;
                end
                else
                begin
                    x0_next    = x_step;
                    root_next  = nprf_pkg::FAIL_ROOT;
                    iter_next  = iter_reg + 10'd1;
                    state_next = S_START;
                end
            end
            S_OUT:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (out_ch.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        x0_reg     <= x0_next;
        xe_reg     <= xe_next;
        y_reg      <= y_next;
        phi_reg    <= phi_next;
        plo_reg    <= plo_next;
        d_reg      <= d_next;
        m_reg      <= m_next;
        pass_reg   <= pass_next;
        term_reg   <= term_next;
        iter_reg   <= iter_next;
        steps_reg  <= steps_next;
        root_reg   <= root_next;
        status_reg <= status_next;
    end

    assign in_ch.ready            = (state_reg == S_IDLE);
    assign out_ch.valid           = (state_reg == S_WAIT);
    assign out_ch.root            = root_reg;
    assign out_ch.status          = status_reg;
    assign out_ch.iterations_used = steps_reg;

endmodule

/* hdl/nprf_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nprf_div: iterative signed divider
// Computes trunc(num / den) one quotient bit per cycle, saturated to 32 bits.
// ----------------------------------------------------------------------------
module nprf_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic               done,
    output logic signed [31:0] quot
);

    logic [63:0] n_reg, n_next;
    logic [63:0] d_reg, d_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] r_reg, r_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [64:0] r_sh;
    logic [63:0] q_signed;

    always_comb
    begin
        n_next    = n_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        r_sh      = {r_reg, n_reg[63]};
        if (start)
        begin
            n_next    = num[63] ? -num : num;
            d_next    = den[63] ? -den : den;
            neg_next  = num[63] ^ den[63];
            q_next    = '0;
            r_next    = '0;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next = {n_reg[62:0], 1'b0};
            if (r_sh >= {1'b0, d_reg})
            begin
                r_next = 64'(r_sh - {1'b0, d_reg});
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = r_sh[63:0];
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        neg_reg <= neg_next;
    end

    // Done pulses in the same cycle that the last quotient bit lands in q_reg.
    logic fin_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_reg <= 1'b0;
        else
            fin_reg <= busy_reg && (cnt_reg == 7'd1);
    end

    assign q_signed = neg_reg ? -q_reg : q_reg;
    assign done     = fin_reg;
    assign quot     = (!neg_reg && q_reg[63:31] != '0) ? 32'sh7FFF_FFFF :
                      (neg_reg && q_reg > 64'h8000_0000) ? 32'sh8000_0000 :
                      q_signed[31:0];

endmodule
